// File: sv/i2cm_pkg.sv
`timescale 1ns / 1ps
// i2cm_pkg: shared types, command and phase codes for the i2c master byte engine
// no dependencies
package i2cm_pkg;

   localparam int BITS_PER_BYTE = 8;

   // command codes
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;
   localparam logic [2:0] CMD_ADDR  = 3'd5;

   // sequencer phase codes, meaning depends on the active command
   localparam logic [2:0] PH_0 = 3'd0;
   localparam logic [2:0] PH_1 = 3'd1;
   localparam logic [2:0] PH_2 = 3'd2;
   localparam logic [2:0] PH_3 = 3'd3;
   localparam logic [2:0] PH_4 = 3'd4;
   localparam logic [2:0] PH_5 = 3'd5;
   localparam logic [2:0] PH_6 = 3'd6;

   // configuration register indexes
   localparam logic CSR_HALF_PERIOD   = 1'b0;
   localparam logic CSR_STRETCH_LIMIT = 1'b1;

   localparam logic [15:0] HALF_PERIOD_RST   = 16'd10;
   localparam logic [15:0] STRETCH_LIMIT_RST = 16'd60000;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] wr_data;
      logic       nack_last;
      logic       scl_in;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rd_data;
      logic       stretch_timeout;
   } rsp_type;

   typedef struct packed {
      logic [15:0] half_period;
      logic [15:0] stretch_limit;
   } cfg_type;

endpackage

// File: sv/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// i2c_master_byte_engine: top level, tick handshake, result register, csr port
// depends on i2cm_pkg, i2cm_csr, i2cm_core
//
//   channel  direction  handshake             beat
//   req_     in         req_valid / req_stall  one tick: cmd, wr_data, nack_last, line levels
//   rsp_     out        rsp_valid / rsp_stall  pin drives and status after that tick
//   csr_     in         csr_valid / csr_ready  register index and 16-bit write data
//
// one req beat makes exactly one rsp beat; a beat can be taken every clock unless req_stall is high
// the sequencer advances in the accept cycle, the result lands in the rsp register
// req_stall rises only while a result is held in the rsp register under rsp_stall
// csr_ready is always high; write only while the engine is idle
// synchronous active-high reset: engine idle, lines released, csr at reset values
module i2c_master_byte_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cm_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   i2cm_pkg::cfg_type cfg;
   i2cm_pkg::rsp_type rsp_next;
   i2cm_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              accept;

   assign csr_ready = 1'b1;

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // a held result blocks new ticks only while downstream stalls
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   i2cm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance_en (accept),
      .req        (req_payload),
      .cfg        (cfg),
      .rsp        (rsp_next)
   );

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, loaded with each accepted tick
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// File: sv/i2cm_csr.sv
`timescale 1ns / 1ps
// i2cm_csr: configuration registers (half period, stretch limit)
// depends on i2cm_pkg
module i2cm_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata,
   output i2cm_pkg::cfg_type cfg
);

   logic [15:0] half_period_ff;
   logic [15:0] half_period_in;
   logic [15:0] stretch_limit_ff;
   logic [15:0] stretch_limit_in;

   always_comb begin
      half_period_in   = half_period_ff;
      stretch_limit_in = stretch_limit_ff;
      if (csr_valid) begin
         case (csr_index)
            i2cm_pkg::CSR_HALF_PERIOD: half_period_in = csr_wdata;
            i2cm_pkg::CSR_STRETCH_LIMIT: stretch_limit_in = csr_wdata;
            default: half_period_in = half_period_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff   <= i2cm_pkg::HALF_PERIOD_RST;
         stretch_limit_ff <= i2cm_pkg::STRETCH_LIMIT_RST;
      end else begin
         half_period_ff   <= half_period_in;
         stretch_limit_ff <= stretch_limit_in;
      end
   end

   assign cfg.half_period   = half_period_ff;
   assign cfg.stretch_limit = stretch_limit_ff;

endmodule

// File: sv/i2cm_core.sv
`timescale 1ns / 1ps
// i2cm_core: bit sequencer state and its one-tick next-state logic
// depends on i2cm_pkg
module i2cm_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance_en,
   input  i2cm_pkg::req_type req,
   input  i2cm_pkg::cfg_type cfg,
   output i2cm_pkg::rsp_type rsp
);

   logic [2:0]  active_ff, active_in;
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] hold_ff, hold_in;
   logic [15:0] stretch_ff, stretch_in;
   logic [1:0]  pin_ff, pin_in;       // [0] scl low, [1] sda low
   logic        ack_ff, ack_in;
   logic [7:0]  last_read_ff, last_read_in;
   logic        timeout_ff, timeout_in;
   logic        done;
   logic [15:0] hold_reload;
   logic        slot_bit;

   assign hold_reload = (cfg.half_period == 16'd0) ? 16'd0 : cfg.half_period - 16'd1;

   always_comb begin
      active_in    = active_ff;
      phase_in     = phase_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      hold_in      = hold_ff;
      stretch_in   = stretch_ff;
      pin_in       = pin_ff;
      ack_in       = ack_ff;
      last_read_in = last_read_ff;
      timeout_in   = timeout_ff;
      done         = 1'b0;
      slot_bit     = 1'b1;

      if (active_ff == i2cm_pkg::CMD_TICK) begin
         if (req.cmd >= i2cm_pkg::CMD_START && req.cmd <= i2cm_pkg::CMD_ADDR) begin
            active_in    = req.cmd;
            phase_in     = i2cm_pkg::PH_0;
            bit_index_in = 4'd0;
            stretch_in   = 16'd0;
            hold_in      = hold_reload;
            if (req.cmd == i2cm_pkg::CMD_START || req.cmd == i2cm_pkg::CMD_STOP) begin
               pin_in = {1'b1, pin_ff[0]};
            end else if (req.cmd == i2cm_pkg::CMD_READ) begin
               ack_in     = req.nack_last;
               timeout_in = 1'b0;
               shift_in   = 8'd0;
               pin_in     = 2'b00;
            end else begin
               // address goes out shifted left with write bit 0
               shift_in = (req.cmd == i2cm_pkg::CMD_ADDR) ? {req.wr_data[6:0], 1'b0}
                                                          : req.wr_data;
               slot_bit = shift_in[7];
               pin_in   = {~slot_bit, pin_ff[0]};
            end
         end
      end else if (active_ff == i2cm_pkg::CMD_READ && phase_ff == i2cm_pkg::PH_1) begin
         // wait for scl high, give up at the stretch limit
         if (req.scl_in || stretch_ff >= cfg.stretch_limit) begin
            if (!req.scl_in) begin
               timeout_in = 1'b1;
            end
            shift_in = {shift_ff[6:0], req.sda_in};
            phase_in = i2cm_pkg::PH_2;
            pin_in   = {pin_ff[1], 1'b1};
            hold_in  = hold_reload;
         end else begin
            stretch_in = stretch_ff + 16'd1;
         end
      end else if (hold_ff != 16'd0) begin
         hold_in = hold_ff - 16'd1;
      end else begin
         case (active_ff)
            i2cm_pkg::CMD_START: begin
               if (phase_ff == i2cm_pkg::PH_0) begin
                  phase_in = i2cm_pkg::PH_1;
                  pin_in   = {pin_ff[1], 1'b1};
                  hold_in  = hold_reload;
               end else begin
                  done = 1'b1;
               end
            end
            i2cm_pkg::CMD_STOP: begin
               if (phase_ff == i2cm_pkg::PH_0) begin
                  phase_in = i2cm_pkg::PH_1;
                  pin_in   = {pin_ff[1], 1'b0};
                  hold_in  = hold_reload;
               end else if (phase_ff == i2cm_pkg::PH_1) begin
                  phase_in = i2cm_pkg::PH_2;
                  pin_in   = {1'b0, pin_ff[0]};
                  hold_in  = hold_reload;
               end else begin
                  done = 1'b1;
               end
            end
            i2cm_pkg::CMD_WRITE, i2cm_pkg::CMD_ADDR: begin
               if (phase_ff == i2cm_pkg::PH_0) begin
                  phase_in = i2cm_pkg::PH_1;
                  pin_in   = {pin_ff[1], 1'b0};
                  hold_in  = hold_reload;
               end else if (phase_ff == i2cm_pkg::PH_1) begin
                  phase_in = i2cm_pkg::PH_2;
                  pin_in   = {pin_ff[1], 1'b1};
                  hold_in  = hold_reload;
               end else begin
                  shift_in     = {shift_ff[6:0], 1'b0};
                  bit_index_in = bit_index_ff + 4'd1;
                  if (bit_index_in >= 4'(i2cm_pkg::BITS_PER_BYTE + 1)) begin
                     done = 1'b1;
                  end else begin
                     // ack slot leaves sda released
                     slot_bit = (bit_index_in >= 4'(i2cm_pkg::BITS_PER_BYTE)) ? 1'b1
                                                                            : shift_in[7];
                     phase_in = i2cm_pkg::PH_0;
                     pin_in   = {~slot_bit, pin_ff[0]};
                     hold_in  = hold_reload;
                  end
               end
            end
            i2cm_pkg::CMD_READ: begin
               case (phase_ff)
                  i2cm_pkg::PH_0: begin
                     phase_in   = i2cm_pkg::PH_1;
                     stretch_in = 16'd0;
                     hold_in    = 16'd0;
                  end
                  i2cm_pkg::PH_2: begin
                     bit_index_in = bit_index_ff + 4'd1;
                     hold_in      = hold_reload;
                     if (bit_index_in >= 4'(i2cm_pkg::BITS_PER_BYTE)) begin
                        last_read_in = shift_ff;
                        phase_in     = i2cm_pkg::PH_3;
                        pin_in       = {~ack_ff, pin_ff[0]};
                     end else begin
                        phase_in = i2cm_pkg::PH_0;
                        pin_in   = 2'b00;
                     end
                  end
                  i2cm_pkg::PH_3: begin
                     phase_in = i2cm_pkg::PH_4;
                     pin_in   = {pin_ff[1], 1'b0};
                     hold_in  = hold_reload;
                  end
                  i2cm_pkg::PH_4: begin
                     phase_in = i2cm_pkg::PH_5;
                     pin_in   = {pin_ff[1], 1'b1};
                     hold_in  = hold_reload;
                  end
                  i2cm_pkg::PH_5: begin
                     phase_in = i2cm_pkg::PH_6;
                     pin_in   = {1'b0, pin_ff[0]};
                     hold_in  = hold_reload;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
            default: begin
               done = 1'b1;
            end
         endcase
         if (done) begin
            active_in = i2cm_pkg::CMD_TICK;
            phase_in  = i2cm_pkg::PH_0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= i2cm_pkg::CMD_TICK;
         phase_ff     <= i2cm_pkg::PH_0;
         bit_index_ff <= 4'd0;
         shift_ff     <= 8'd0;
         hold_ff      <= 16'd0;
         stretch_ff   <= 16'd0;
         pin_ff       <= 2'b00;
         ack_ff       <= 1'b0;
         last_read_ff <= 8'd0;
         timeout_ff   <= 1'b0;
      end else if (advance_en) begin
         active_ff    <= active_in;
         phase_ff     <= phase_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         hold_ff      <= hold_in;
         stretch_ff   <= stretch_in;
         pin_ff       <= pin_in;
         ack_ff       <= ack_in;
         last_read_ff <= last_read_in;
         timeout_ff   <= timeout_in;
      end
   end

   assign rsp.scl_pull_low    = pin_in[0];
   assign rsp.sda_pull_low    = pin_in[1];
   assign rsp.busy_res        = (active_in != i2cm_pkg::CMD_TICK);
   assign rsp.done_res        = done;
   assign rsp.rd_data         = last_read_in;
   assign rsp.stretch_timeout = timeout_in;

   // idle engine always sits in the first phase
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      (active_ff == i2cm_pkg::CMD_TICK) |-> (phase_ff == i2cm_pkg::PH_0))
      else $error("idle engine with nonzero phase");

   // slot counter never runs more than one past the ack slot (BITS_PER_BYTE + 1)
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= 4'(i2cm_pkg::BITS_PER_BYTE + 1))
      else $error("bit index out of range");

   // completion only from a busy engine, and it leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (advance_en && done) |=> (active_ff == i2cm_pkg::CMD_TICK &&
                                $past(active_ff) != i2cm_pkg::CMD_TICK))
      else $error("done without a finished command");

endmodule
